/* design/dmsr_pkg.sv */
// Shared types, constants and helper functions for the dual motor slew ramp.
// Used by dmsr_div, dmsr_ramp, dmsr_checker and the top level dual_motor_slew_ramp.
`default_nettype none

package dmsr_pkg;

  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int SPEED_W  = 9;
  localparam int DUTY_W   = 8;
  localparam int STEP_W   = 4;

  localparam logic [STEP_W-1:0]          MAX_STEPS     = 4'd10;
  localparam logic signed [SPEED_W-1:0]  SPEED_MAX     = 9'sd255;
  localparam logic [PERIOD_W-1:0]        PERIOD_RESET  = 16'd10;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [STEP_W-1:0] k;
  } dmsr_div_stat_t;

  // Clamp a target speed into the symmetric range (only -256 moves).
  function automatic logic signed [SPEED_W-1:0] sat_target(
      input logic signed [SPEED_W-1:0] v);
    return (v < -SPEED_MAX) ? -SPEED_MAX : v;
  endfunction

  function automatic logic [DUTY_W-1:0] pos_duty(input logic signed [SPEED_W-1:0] v);
    return (v > 0) ? v[DUTY_W-1:0] : '0;
  endfunction

  function automatic logic [DUTY_W-1:0] neg_duty(input logic signed [SPEED_W-1:0] v);
    logic signed [SPEED_W-1:0] m;
    m = -v;
    return (v < 0) ? m[DUTY_W-1:0] : '0;
  endfunction

endpackage

`default_nettype wire

/* design/dmsr_div.sv */
// Bit-serial restoring divider: elapsed time over step period, one quotient bit a cycle.
// Reports the quotient clamped to the maximum step count. Depends on dmsr_pkg.
`default_nettype none

module dmsr_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [dmsr_pkg::TIME_W-1:0]   dividend,
  input  wire logic [dmsr_pkg::PERIOD_W-1:0] divisor,
  output dmsr_pkg::dmsr_div_stat_t           stat
);

  localparam int CNT_W = $clog2(dmsr_pkg::TIME_W);

  logic [dmsr_pkg::TIME_W-1:0]   dvd;
  logic [dmsr_pkg::PERIOD_W-1:0] rem;
  logic [dmsr_pkg::STEP_W-1:0]   q;
  logic                          qsat;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic                          done;

  logic [dmsr_pkg::PERIOD_W-1:0] div_eff;
  logic [dmsr_pkg::PERIOD_W:0]   trial;
  logic [dmsr_pkg::PERIOD_W:0]   diff;
  logic                          ge;

  // A zero period counts as one millisecond.
  assign div_eff = (divisor == '0) ? dmsr_pkg::PERIOD_W'(1) : divisor;
  assign trial   = {rem, dvd[dmsr_pkg::TIME_W-1]};
  assign ge      = (trial >= {1'b0, div_eff});
  assign diff    = trial - {1'b0, div_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
        q    <= '0;
        qsat <= 1'b0;
      end else if (busy) begin
        dvd  <= {dvd[dmsr_pkg::TIME_W-2:0], 1'b0};
        rem  <= ge ? diff[dmsr_pkg::PERIOD_W-1:0] : trial[dmsr_pkg::PERIOD_W-1:0];
        // Keep only the low quotient bits; remember any overflow past them.
        qsat <= qsat | q[dmsr_pkg::STEP_W-1];
        q    <= {q[dmsr_pkg::STEP_W-2:0], ge};
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(dmsr_pkg::TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.k    = (qsat || (q > dmsr_pkg::MAX_STEPS)) ? dmsr_pkg::MAX_STEPS : q;

endmodule

`default_nettype wire

/* design/dmsr_ramp.sv */
// One channel of the slew limiter: move the speed toward its goal by k, no overshoot.
// Depends on dmsr_pkg for widths and the speed limit.
`default_nettype none

module dmsr_ramp (
  input  wire logic signed [dmsr_pkg::SPEED_W-1:0] cur,
  input  wire logic signed [dmsr_pkg::SPEED_W-1:0] goal,
  input  wire logic        [dmsr_pkg::STEP_W-1:0]  k,
  output logic signed      [dmsr_pkg::SPEED_W-1:0] nxt
);

  localparam int WIDE_W = dmsr_pkg::SPEED_W + 2;

  logic signed [WIDE_W-1:0] c;
  logic signed [WIDE_W-1:0] g;
  logic signed [WIDE_W-1:0] kk;
  logic signed [WIDE_W-1:0] lim;
  logic signed [WIDE_W-1:0] n;

  assign c   = WIDE_W'(cur);
  assign g   = WIDE_W'(goal);
  assign kk  = {{(WIDE_W-dmsr_pkg::STEP_W){1'b0}}, k};
  assign lim = WIDE_W'(dmsr_pkg::SPEED_MAX);

  always_comb begin
    if (c > g) begin
      n = c - kk;
      if (n < g) n = g;
    end else begin
      n = c + kk;
      if (n > g) n = g;
    end
    if (n > lim) n = lim;
    if (n < -lim) n = -lim;
  end

  assign nxt = n[dmsr_pkg::SPEED_W-1:0];

endmodule

`default_nettype wire

/* design/dual_motor_slew_ramp.sv */
// Top level of the two-channel slew-limited H-bridge PWM drive.
// Instantiates dmsr_div and two dmsr_ramp channels; depends on dmsr_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per item. kind = 0 stores
//   target_right/target_left (clamped to +-255) and restarts the step timer at
//   now_ms. kind = 1 is a tick carrying the millisecond time; once at least one
//   step period has gone by since the last restart, each speed moves toward its
//   target by min(elapsed / period, 10) and the timer restarts at now_ms.
//   Output channel (out_valid/out_ready): one request per item, the four PWM
//   duties (positive and negative parts of each channel speed).
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes step_period_ms; always
//   ready, write it only while the block is idle. Zero acts as one.
// Sequencing:
//   A set-target request passes through ST_DONE into the output register. A tick
//   waits in ST_DIV while the bit-serial divider works, one quotient bit a cycle
//   over the 32-bit elapsed time, then passes through ST_DONE into the output
//   register. One item is in work at a time; the next is accepted the cycle after
//   its result is loaded into the output register.
// Reset: rst (synchronous) zeroes speeds, targets and the timer, sets the period
//   to 10 ms and empties the output register.
// Stall: a result waits in the output register while out_ready is low; a newer
//   result holds in the sequencer until that slot frees.
`default_nettype none

module dual_motor_slew_ramp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           kind,
  input  wire logic signed [dmsr_pkg::SPEED_W-1:0] target_right,
  input  wire logic signed [dmsr_pkg::SPEED_W-1:0] target_left,
  input  wire logic [dmsr_pkg::TIME_W-1:0]    now_ms,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [dmsr_pkg::DUTY_W-1:0]         right_forward_duty,
  output logic [dmsr_pkg::DUTY_W-1:0]         right_back_duty,
  output logic [dmsr_pkg::DUTY_W-1:0]         left_forward_duty,
  output logic [dmsr_pkg::DUTY_W-1:0]         left_back_duty,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dmsr_pkg::PERIOD_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state;

  logic [dmsr_pkg::PERIOD_W-1:0]   step_period_ms;
  logic signed [dmsr_pkg::SPEED_W-1:0] right_speed;
  logic signed [dmsr_pkg::SPEED_W-1:0] left_speed;
  logic signed [dmsr_pkg::SPEED_W-1:0] right_goal;
  logic signed [dmsr_pkg::SPEED_W-1:0] left_goal;
  logic [dmsr_pkg::TIME_W-1:0]     last_update_ms;
  logic [dmsr_pkg::TIME_W-1:0]     tick_ms;

  logic                            in_acc;
  logic                            div_start;
  logic [dmsr_pkg::TIME_W-1:0]     elapsed;
  dmsr_pkg::dmsr_div_stat_t        div_stat;
  logic signed [dmsr_pkg::SPEED_W-1:0] right_next;
  logic signed [dmsr_pkg::SPEED_W-1:0] left_next;
  logic                            slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign div_start = in_acc && kind;
  // Wraps modulo 2^32, so a time stamp that went backwards reads as long elapsed.
  assign elapsed   = now_ms - last_update_ms;
  assign slot_free = !out_valid || out_ready;

  dmsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed),
    .divisor  (step_period_ms),
    .stat     (div_stat)
  );

  dmsr_ramp u_ramp_right (
    .cur  (right_speed),
    .goal (right_goal),
    .k    (div_stat.k),
    .nxt  (right_next)
  );

  dmsr_ramp u_ramp_left (
    .cur  (left_speed),
    .goal (left_goal),
    .k    (div_stat.k),
    .nxt  (left_next)
  );

  // Config register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_period_ms <= dmsr_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_period_ms <= cfg_data;
    end
  end

  // Sequencer, ramp state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      right_speed    <= '0;
      left_speed     <= '0;
      right_goal     <= '0;
      left_goal      <= '0;
      last_update_ms <= '0;
    end else begin
      // Drop the shown result once taken, unless a new one replaces it.
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (kind) begin
              // Hold the tick time and let the divider run.
              tick_ms <= now_ms;
              state   <= ST_DIV;
            end else begin
              right_goal     <= dmsr_pkg::sat_target(target_right);
              left_goal      <= dmsr_pkg::sat_target(target_left);
              last_update_ms <= now_ms;
              state          <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            // A nonzero step count means at least one period went by.
            if (div_stat.k != '0) begin
              right_speed    <= right_next;
              left_speed     <= left_next;
              last_update_ms <= tick_ms;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            right_forward_duty <= dmsr_pkg::pos_duty(right_speed);
            right_back_duty    <= dmsr_pkg::neg_duty(right_speed);
            left_forward_duty  <= dmsr_pkg::pos_duty(left_speed);
            left_back_duty     <= dmsr_pkg::neg_duty(left_speed);
            out_valid          <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/dmsr_checker.sv */
// Port-level checks for dual_motor_slew_ramp, attached by the bind at the bottom.
// Sees only the top level's ports; depends on dmsr_pkg for widths.
`default_nettype none

module dmsr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [dmsr_pkg::DUTY_W-1:0]   right_forward_duty,
  input wire logic [dmsr_pkg::DUTY_W-1:0]   right_back_duty,
  input wire logic [dmsr_pkg::DUTY_W-1:0]   left_forward_duty,
  input wire logic [dmsr_pkg::DUTY_W-1:0]   left_back_duty
);

  // A stalled result holds its duties.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(right_forward_duty) &&
      $stable(right_back_duty) && $stable(left_forward_duty) && $stable(left_back_duty))
    else $error("stalled result changed or dropped");

  // While a result is shown, forward and back never drive together on one bridge.
  a_right_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (right_forward_duty == '0) || (right_back_duty == '0))
    else $error("right bridge driven both ways");

  a_left_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_forward_duty == '0) || (left_back_duty == '0))
    else $error("left bridge driven both ways");

  // One request in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while one is in work");

endmodule

bind dual_motor_slew_ramp dmsr_checker u_dmsr_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .right_forward_duty (right_forward_duty),
  .right_back_duty    (right_back_duty),
  .left_forward_duty  (left_forward_duty),
  .left_back_duty     (left_back_duty)
);

`default_nettype wire
